/* sv/mqrr_pkg.sv */
// ----------------------------------------------------------------------------
// mqrr_pkg
// Shared types and constants of the multi-queue round-robin scheduler.
// ----------------------------------------------------------------------------
`default_nettype none

package mqrr_pkg;

    localparam int LIMIT_W     = 10;
    localparam int TOTAL_W     = LIMIT_W + 1;
    localparam int QINDEX_W    = 8;
    localparam int HANDLE_W    = 32;
    localparam int FROMQ_W     = 5;
    localparam int STATUS_W    = 3;
    localparam int S_TDATA_W   = 40;
    localparam int M_TDATA_W   = 40;
    localparam int M_PAD_W     = M_TDATA_W - HANDLE_W - FROMQ_W;

    localparam logic [LIMIT_W-1:0] LIMIT_RESET = 10'd500;

    localparam logic REQ_ENQ = 1'b0;
    localparam logic REQ_DEQ = 1'b1;

    typedef enum logic [STATUS_W-1:0] {
        STAT_ACCEPT = 3'd0,
        STAT_OVER   = 3'd1,
        STAT_FULL   = 3'd2,
        STAT_DEQ    = 3'd3,
        STAT_EMPTY  = 3'd4,
        STAT_BADIDX = 3'd5
    } status_t;

    typedef enum logic [3:0] {
        S_IDLE   = 4'b0001,
        S_LOOKUP = 4'b0010,
        S_UPDATE = 4'b0100,
        S_RESULT = 4'b1000
    } state_t;

endpackage

`default_nettype wire

/* sv/multi_queue_round_robin_scheduler_core.sv */
// ----------------------------------------------------------------------------
// multi_queue_round_robin_scheduler_core
// Drop-tail packet scheduler with NUM_QUEUES FIFO queues served round-robin.
//
// Input channel s_*: s_tuser is the request (0 enqueue, 1 dequeue); s_tdata
// carries the queue index and the packet handle. Output channel m_*: one
// result item per request; m_tuser is the status, m_tdata the popped handle
// and the queue number. cfg_we/cfg_wdata write the packet limit (reset 500).
//
// A request that reaches a queue goes through accept and round-robin pick,
// read of the per-queue pointer memory, read-modify-write of that memory with
// the packet store access, and load of the output register. A drop over the
// limit or for a bad index, and a dequeue with every queue empty, go straight
// to the output load. One request is in work at a time. A result waiting in
// the output register does not block the next accept; a stalled receiver
// holds the block in its output load step until the output register frees
// up.
//
// Reset empties every queue at once (per-queue valid bits), sets one active
// queue and the round-robin pointer to queue 0. The packet store is not
// cleared; it is read only at entries already written.
// ----------------------------------------------------------------------------
`default_nettype none

module multi_queue_round_robin_scheduler_core #(
    parameter int NUM_QUEUES   = 32,
    parameter int QUEUE_DEPTH  = 512,
    parameter int HANDLE_WIDTH = 32
) (
    input  wire logic                             clk,
    input  wire logic                             rst_n,
    input  wire logic                             cfg_we,
    input  wire logic [mqrr_pkg::LIMIT_W-1:0]     cfg_wdata,
    input  wire logic                             s_tvalid,
    output logic                                  s_tready,
    // queue_index [7:0], packet_handle [39:8]
    input  wire logic [mqrr_pkg::S_TDATA_W-1:0]   s_tdata,
    // req_type [0]
    input  wire logic [0:0]                       s_tuser,
    output logic                                  m_tvalid,
    input  wire logic                             m_tready,
    // out_handle [31:0], from_queue [36:32], zero [39:37]
    output logic [mqrr_pkg::M_TDATA_W-1:0]        m_tdata,
    // status [2:0]
    output logic [mqrr_pkg::STATUS_W-1:0]         m_tuser
);

    import mqrr_pkg::*;

    localparam int QW = (NUM_QUEUES > 1) ? $clog2(NUM_QUEUES) : 1;
    localparam int PW = $clog2(QUEUE_DEPTH);
    localparam int CW = $clog2(QUEUE_DEPTH + 1);
    localparam int AW = $clog2(NUM_QUEUES + 1);
    localparam int SW = (HANDLE_WIDTH < HANDLE_W) ? HANDLE_WIDTH : HANDLE_W;
    localparam int STORE_DEPTH = NUM_QUEUES * (2 ** PW);

    typedef struct packed {
        logic [PW-1:0] head;
        logic [PW-1:0] tail;
        logic [CW-1:0] count;
    } qentry_t;

    // Memories
    qentry_t         queue_mem [NUM_QUEUES];
    logic [SW-1:0]   packet_store_mem [STORE_DEPTH];

    // Control registers
    state_t                  state_reg, state_next;
    logic [LIMIT_W-1:0]      limit_reg, limit_next;
    logic [TOTAL_W-1:0]      total_reg, total_next;
    logic [AW-1:0]           active_reg, active_next;
    logic [QW-1:0]           rr_reg, rr_next;
    logic [NUM_QUEUES-1:0]   nonempty_reg, nonempty_next;
    logic [NUM_QUEUES-1:0]   qvalid_reg, qvalid_next;
    logic                    m_tvalid_reg, m_tvalid_next;

    // Payload registers
    logic                    req_reg, req_next;
    logic [QW-1:0]           target_reg, target_next;
    logic [SW-1:0]           handle_reg, handle_next;
    status_t                 status_reg, status_next;
    qentry_t                 qrd_reg;
    logic                    qrd_valid_reg;
    logic [SW-1:0]           store_rd_reg;
    logic [M_TDATA_W-1:0]    m_tdata_reg, m_tdata_next;
    logic [STATUS_W-1:0]     m_tuser_reg, m_tuser_next;

    // Memory access controls
    logic                    qmem_we;
    qentry_t                 qmem_wdata;
    logic                    store_we;
    logic                    store_re;
    logic [QW+PW-1:0]        store_addr;

    // Round-robin pick
    logic                    hit_hi, hit_any;
    logic [QW-1:0]           q_hi, q_any;

    logic [QINDEX_W-1:0]     in_qindex;
    qentry_t                 entry;
    logic                    out_free;
    logic                    queue_full;

    assign in_qindex = s_tdata[QINDEX_W-1:0];
    assign s_tready  = (state_reg == S_IDLE);
    assign m_tvalid  = m_tvalid_reg;
    assign m_tdata   = m_tdata_reg;
    assign m_tuser   = m_tuser_reg;
    assign out_free  = !m_tvalid_reg || m_tready;
    assign entry     = qrd_valid_reg ? qrd_reg : '0;
    assign queue_full = (int'(entry.count) >= int'(limit_reg))
                     || (int'(entry.count) >= QUEUE_DEPTH);

    always_comb
    begin
        hit_hi  = 1'b0;
        hit_any = 1'b0;
        q_hi    = '0;
        q_any   = '0;
        for (int i = NUM_QUEUES - 1; i >= 0; i--)
        begin
            if (nonempty_reg[i])
            begin
                hit_any = 1'b1;
                q_any   = QW'(i);
                if (i >= int'(rr_reg))
                begin
                    hit_hi = 1'b1;
                    q_hi   = QW'(i);
                end
            end
        end
    end

    always_comb
    begin
        state_next    = state_reg;
        limit_next    = cfg_we ? cfg_wdata : limit_reg;
        total_next    = total_reg;
        active_next   = active_reg;
        rr_next       = rr_reg;
        nonempty_next = nonempty_reg;
        qvalid_next   = qvalid_reg;
        m_tvalid_next = m_tvalid_reg;
        req_next      = req_reg;
        target_next   = target_reg;
        handle_next   = handle_reg;
        status_next   = status_reg;
        m_tdata_next  = m_tdata_reg;
        m_tuser_next  = m_tuser_reg;
        qmem_we       = 1'b0;
        qmem_wdata    = entry;
        store_we      = 1'b0;
        store_re      = 1'b0;
        store_addr    = {target_reg, entry.tail};

        if (m_tvalid_reg && m_tready)
        begin
            m_tvalid_next = 1'b0;
        end

        unique case (state_reg)
            S_IDLE:
            begin
                if (s_tvalid)
                begin
                    req_next    = s_tuser[0];
                    handle_next = s_tdata[QINDEX_W +: SW];
                    target_next = '0;
                    state_next  = S_LOOKUP;
                    if (s_tuser[0] == REQ_ENQ)
                    begin
                        if (total_reg > {1'b0, limit_reg})
                        begin
                            status_next = STAT_OVER;
                            state_next  = S_RESULT;
                        end
                        else if (int'(in_qindex) >= NUM_QUEUES)
                        begin
                            status_next = STAT_BADIDX;
                            state_next  = S_RESULT;
                        end
                        else
                        begin
                            target_next = QW'(in_qindex);
                            if (int'(in_qindex) + 1 > int'(active_reg))
                            begin
                                active_next = AW'(int'(in_qindex) + 1);
                            end
                        end
                    end
                    else if (!hit_any)
                    begin
                        status_next = STAT_EMPTY;
                        state_next  = S_RESULT;
                    end
                    else
                    begin
                        target_next = hit_hi ? q_hi : q_any;
                    end
                end
            end

            S_LOOKUP:
            begin
                state_next = S_UPDATE;
            end

            S_UPDATE:
            begin
                state_next = S_RESULT;
                if (req_reg == REQ_ENQ)
                begin
                    if (queue_full)
                    begin
                        status_next = STAT_FULL;
                    end
                    else
                    begin
                        store_we   = 1'b1;
                        store_addr = {target_reg, entry.tail};
                        qmem_we    = 1'b1;
                        qmem_wdata.tail = (int'(entry.tail) + 1 == QUEUE_DEPTH)
                                        ? '0 : PW'(int'(entry.tail) + 1);
                        qmem_wdata.count = entry.count + CW'(1);
                        qvalid_next[target_reg]   = 1'b1;
                        nonempty_next[target_reg] = 1'b1;
                        total_next  = total_reg + TOTAL_W'(1);
                        status_next = STAT_ACCEPT;
                    end
                end
                else
                begin
                    store_re   = 1'b1;
                    store_addr = {target_reg, entry.head};
                    qmem_we    = 1'b1;
                    qmem_wdata.head = (int'(entry.head) + 1 == QUEUE_DEPTH)
                                    ? '0 : PW'(int'(entry.head) + 1);
                    qmem_wdata.count = entry.count - CW'(1);
                    qvalid_next[target_reg]   = 1'b1;
                    nonempty_next[target_reg] = (entry.count != CW'(1));
                    if (total_reg != '0)
                    begin
                        total_next = total_reg - TOTAL_W'(1);
                    end
                    rr_next = (int'(target_reg) + 1 >= int'(active_reg))
                            ? '0 : QW'(int'(target_reg) + 1);
                    status_next = STAT_DEQ;
                end
            end

            S_RESULT:
            begin
                if (out_free)
                begin
                    m_tvalid_next = 1'b1;
                    m_tuser_next  = status_reg;
                    m_tdata_next  = {{M_PAD_W{1'b0}}, FROMQ_W'(target_reg),
                                     (status_reg == STAT_DEQ)
                                         ? HANDLE_W'(store_rd_reg) : {HANDLE_W{1'b0}}};
                    state_next    = S_IDLE;
                end
            end

            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= S_IDLE;
            limit_reg    <= LIMIT_RESET;
            total_reg    <= '0;
            active_reg   <= AW'(1);
            rr_reg       <= '0;
            nonempty_reg <= '0;
            qvalid_reg   <= '0;
            m_tvalid_reg <= 1'b0;
        end
        else
        begin
            state_reg    <= state_next;
            limit_reg    <= limit_next;
            total_reg    <= total_next;
            active_reg   <= active_next;
            rr_reg       <= rr_next;
            nonempty_reg <= nonempty_next;
            qvalid_reg   <= qvalid_next;
            m_tvalid_reg <= m_tvalid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        req_reg     <= req_next;
        target_reg  <= target_next;
        handle_reg  <= handle_next;
        status_reg  <= status_next;
        m_tdata_reg <= m_tdata_next;
        m_tuser_reg <= m_tuser_next;
    end

    // Per-queue pointer memory
    always_ff @(posedge clk)
    begin
        if (qmem_we)
        begin
            queue_mem[target_reg] <= qmem_wdata;
        end
        if (state_reg == S_LOOKUP)
        begin
            qrd_reg       <= queue_mem[target_reg];
            qrd_valid_reg <= qvalid_reg[target_reg];
        end
    end

    // Packet store
    always_ff @(posedge clk)
    begin
        if (store_we)
        begin
            packet_store_mem[store_addr] <= handle_reg;
        end
        if (store_re)
        begin
            store_rd_reg <= packet_store_mem[store_addr];
        end
    end

endmodule

`default_nettype wire
